/* rtl/accel_activity_step_tracker_top_assert.svh */
// Assertion helpers shared by the step tracker RTL.
// Each helper expects clk and rst to be visible where it is used.
`ifndef ACCEL_ACTIVITY_STEP_TRACKER_TOP_ASSERT_SVH
`define ACCEL_ACTIVITY_STEP_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define AAST_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define AAST_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/aast_pkg.sv */
`timescale 1ns / 1ps

package aast_pkg;

  // Field widths of the item and result channels.
  localparam int unsigned ACC_W      = 16;
  localparam int unsigned TS_W       = 32;
  localparam int unsigned STEP_LEN_W = 11;
  localparam int unsigned THR_W      = 15;
  localparam int unsigned CNT_W      = 24;
  localparam int unsigned DIST_W     = 35;
  localparam int unsigned SPD_W      = 21;
  localparam int unsigned MAG_W      = 16;

  // Sum of three squares and its integer root.
  localparam int unsigned SQ_W   = 32;
  localparam int unsigned ROOT_W = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // One g in Q13.
  localparam logic [ROOT_W-1:0] ONE_G    = 16'd8192;
  localparam logic [CNT_W-1:0]  STEP_MAX = '1;
  localparam logic [SPD_W-1:0]  MS_PER_S = 21'd1000;

  // Register values after reset.
  localparam logic [STEP_LEN_W-1:0] STEP_LEN_RST = 11'd600;
  localparam logic [THR_W-1:0]      REST_THR_RST = 15'd819;
  localparam logic [THR_W-1:0]      RUN_THR_RST  = 15'd4096;
  localparam logic [THR_W-1:0]      STEP_THR_RST = 15'd4096;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_LENGTH = 8'd0,
    REG_REST_THR    = 8'd1,
    REG_RUN_THR     = 8'd2,
    REG_STEP_THR    = 8'd3
  } cfg_reg_t;

  // Activity classes.
  typedef enum logic [1:0] {
    ACT_REST = 2'd0,
    ACT_WALK = 2'd1,
    ACT_RUN  = 2'd2
  } activity_t;

endpackage

/* rtl/aast_mul.sv */
`timescale 1ns / 1ps

// Shift-and-add multiplier: one bit of b per cycle.
module aast_mul #(
  parameter int unsigned A_W = 16,
  parameter int unsigned B_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [A_W-1:0]   a,
  input  logic [B_W-1:0]   b,
  output logic             busy,
  output logic [A_W+B_W-1:0] product
);

  localparam int unsigned P_W    = A_W + B_W;
  localparam int unsigned ITER_W = (B_W > 1) ? $clog2(B_W) : 1;

  logic [P_W-1:0]    mcand;
  logic [B_W-1:0]    mplier;
  logic [ITER_W-1:0] iter;

  // Iteration count and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= '0;
    end else if (busy) begin
      if (iter == ITER_W'(B_W - 1)) begin
        busy <= 1'b0;
      end
      iter <= iter + 1'b1;
    end
  end

  // Partial products are added as the multiplier bits shift out.
  always_ff @(posedge clk) begin
    if (start) begin
      mcand   <= P_W'(a);
      mplier  <= b;
      product <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        product <= product + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

endmodule

/* rtl/aast_sqrt.sv */
`timescale 1ns / 1ps

// Restoring integer square root: two radicand bits per cycle, one root bit out.
module aast_sqrt
  import aast_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic              busy,
  output logic [ROOT_W-1:0] root
);

  localparam int unsigned ITER   = SQ_W / 2;
  localparam int unsigned ITER_W = $clog2(ITER);

  logic [SQ_W-1:0]     rad;
  logic [ROOT_W:0]     rem;
  logic [ROOT_W+2:0]   rem_shift;
  logic [ROOT_W+2:0]   trial;
  logic [ROOT_W+2:0]   diff;
  logic                fits;
  logic [ITER_W-1:0]   iter;

  // Bring down the next bit pair and try the next root bit.
  assign rem_shift = {rem, rad[SQ_W-1 -: 2]};
  assign trial     = {1'b0, root, 2'b01};
  assign fits      = (rem_shift >= trial);
  assign diff      = rem_shift - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= '0;
    end else if (busy) begin
      if (iter == ITER_W'(ITER - 1)) begin
        busy <= 1'b0;
      end
      iter <= iter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= fits ? diff[ROOT_W:0] : rem_shift[ROOT_W:0];
      root <= {root[ROOT_W-2:0], fits};
    end
  end

endmodule

/* rtl/aast_div.sv */
`timescale 1ns / 1ps

// Restoring divider: one quotient bit per cycle.
// A zero divisor gives an all-ones quotient; the caller handles that case.
module aast_div #(
  parameter int unsigned NUM_W = 21,
  parameter int unsigned DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);

  localparam int unsigned ITER_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W:0]    rem_shift;
  logic [DEN_W:0]    diff;
  logic              fits;
  logic [ITER_W-1:0] iter;

  // The quotient register doubles as the numerator shift register.
  assign rem_shift = {rem, quotient[NUM_W-1]};
  assign fits      = (rem_shift >= {1'b0, den_q});
  assign diff      = rem_shift - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= '0;
    end else if (busy) begin
      if (iter == ITER_W'(NUM_W - 1)) begin
        busy <= 1'b0;
      end
      iter <= iter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den_q    <= denom;
      quotient <= numer;
    end else if (busy) begin
      rem      <= fits ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
      quotient <= {quotient[NUM_W-2:0], fits};
    end
  end

endmodule

/* rtl/accel_activity_step_tracker_top.sv */
`timescale 1ns / 1ps
// Flow: an accepted item is squared in three serial multiplier lanes, summed, passed through
// the serial root and the window update, then divided for the window average; on a step the
// speed division and the distance multiply follow before the output state loads the result.
// Only one item is in flight; the next is accepted once the result is in the output register.
// Reset: synchronous, active high; control and configuration registers return to defaults, the
// window reads as zero through per-entry valid bits, so no clearing pass is needed.
`include "accel_activity_step_tracker_top_assert.svh"

module accel_activity_step_tracker_top
  import aast_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Sample items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [ACC_W-1:0] acc_x,
  input  logic signed [ACC_W-1:0] acc_y,
  input  logic signed [ACC_W-1:0] acc_z,
  input  logic [TS_W-1:0]       timestamp_ms,
  // Result items
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            activity,
  output logic                  step_detected,
  output logic [CNT_W-1:0]      step_total,
  output logic [DIST_W-1:0]     distance_mm,
  output logic [SPD_W-1:0]      speed_mm_per_s,
  output logic [MAG_W-1:0]      window_mean
);

  localparam int unsigned WP_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned SUM_W = $clog2(WINDOW_LEN) + MAG_W;
  localparam int unsigned DIV_W = (SUM_W > SPD_W) ? SUM_W : SPD_W;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_SQ   = 11'b000_0000_0010,
    S_ADD  = 11'b000_0000_0100,
    S_ROOT = 11'b000_0000_1000,
    S_UPD  = 11'b000_0001_0000,
    S_AVG  = 11'b000_0010_0000,
    S_AVGW = 11'b000_0100_0000,
    S_DEC  = 11'b000_1000_0000,
    S_SPD  = 11'b001_0000_0000,
    S_SPDW = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers
  logic [STEP_LEN_W-1:0] step_len;
  logic [THR_W-1:0]      rest_thr;
  logic [THR_W-1:0]      run_thr;
  logic [THR_W-1:0]      step_thr;

  // Latched item
  logic [ACC_W-1:0] abs_x;
  logic [ACC_W-1:0] abs_y;
  logic [ACC_W-1:0] abs_z;
  logic [TS_W-1:0]  ts_q;

  // Serial unit signals
  logic              sq_start;
  logic              sq_busy;
  logic              sq_busy_y;
  logic              sq_busy_z;
  logic [SQ_W-1:0]   sq_x;
  logic [SQ_W-1:0]   sq_y;
  logic [SQ_W-1:0]   sq_z;
  logic [SQ_W-1:0]   sq_xy;
  logic              root_start;
  logic              root_busy;
  logic [ROOT_W-1:0] root;
  logic              div_start;
  logic              div_busy;
  logic [DIV_W-1:0]  div_num;
  logic [TS_W-1:0]   div_den;
  logic [DIV_W-1:0]  div_quo;
  logic              dist_start;
  logic              dist_busy;
  logic [DIST_W-1:0] dist_prod;
  logic [SPD_W-1:0]  spd_num;

  // Window
  logic [MAG_W-1:0]      win_mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] win_vld;
  logic [MAG_W-1:0]      rd_data;
  logic [MAG_W-1:0]      old_mag;
  logic [MAG_W-1:0]      net;
  logic [WP_W-1:0]       wp;
  logic [SUM_W-1:0]      win_sum;
  logic [SUM_W-1:0]      win_sum_next;

  // Step tracking
  logic [MAG_W-1:0]  avg;
  logic              armed;
  logic              step_now;
  logic              step_q;
  activity_t         act_next;
  activity_t         act_q;
  logic [CNT_W-1:0]  step_cnt;
  logic [TS_W-1:0]   last_ts;
  logic [TS_W-1:0]   delta;
  logic [DIST_W-1:0] dist_hold;
  logic [SPD_W-1:0]  spd_hold;

  logic in_acc;
  logic out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  // Configuration register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_len <= STEP_LEN_RST;
      rest_thr <= REST_THR_RST;
      run_thr  <= RUN_THR_RST;
      step_thr <= STEP_THR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STEP_LENGTH: step_len <= cfg_data[STEP_LEN_W-1:0];
        REG_REST_THR:    rest_thr <= cfg_data[THR_W-1:0];
        REG_RUN_THR:     run_thr  <= cfg_data[THR_W-1:0];
        REG_STEP_THR:    step_thr <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_SQ;
      S_SQ:   if (!sq_start && !sq_busy) state_next = S_ADD;
      S_ADD:  state_next = S_ROOT;
      S_ROOT: if (!root_busy) state_next = S_UPD;
      S_UPD:  state_next = S_AVG;
      S_AVG:  state_next = S_AVGW;
      S_AVGW: if (!div_busy) state_next = S_DEC;
      S_DEC:  state_next = step_now ? S_SPD : S_OUT;
      S_SPD:  state_next = S_SPDW;
      S_SPDW: if (!div_busy && !dist_busy) state_next = S_OUT;
      S_OUT:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the item as magnitudes for the squaring lanes.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      abs_x <= acc_x[ACC_W-1] ? (~acc_x + 1'b1) : acc_x;
      abs_y <= acc_y[ACC_W-1] ? (~acc_y + 1'b1) : acc_y;
      abs_z <= acc_z[ACC_W-1] ? (~acc_z + 1'b1) : acc_z;
      ts_q  <= timestamp_ms;
    end
  end

  // Squaring lanes start the cycle after the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_start <= 1'b0;
    end else begin
      sq_start <= in_acc;
    end
  end

  aast_mul #(.A_W(ACC_W), .B_W(ACC_W)) u_sq_x (
    .clk(clk), .rst(rst), .start(sq_start), .a(abs_x), .b(abs_x),
    .busy(sq_busy), .product(sq_x)
  );
  aast_mul #(.A_W(ACC_W), .B_W(ACC_W)) u_sq_y (
    .clk(clk), .rst(rst), .start(sq_start), .a(abs_y), .b(abs_y),
    .busy(sq_busy_y), .product(sq_y)
  );
  aast_mul #(.A_W(ACC_W), .B_W(ACC_W)) u_sq_z (
    .clk(clk), .rst(rst), .start(sq_start), .a(abs_z), .b(abs_z),
    .busy(sq_busy_z), .product(sq_z)
  );

  // The first two squares are summed once the lanes have finished.
  always_ff @(posedge clk) begin
    if (state == S_SQ && !sq_start && !sq_busy && !sq_busy_y && !sq_busy_z) begin
      sq_xy <= sq_x + sq_y;
    end
  end

  assign root_start = (state == S_ADD);

  aast_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(root_start), .radicand(sq_xy + sq_z),
    .busy(root_busy), .root(root)
  );

  // Net magnitude: distance of the root from one g.
  assign net = (root >= ONE_G) ? (root - ONE_G) : (ONE_G - root);

  // The window entry being replaced is read ahead; it reads as zero until written.
  always_ff @(posedge clk) begin
    rd_data <= win_mem[wp];
  end

  always_ff @(posedge clk) begin
    if (state == S_UPD) begin
      win_mem[wp] <= net;
    end
  end

  assign old_mag      = win_vld[wp] ? rd_data : '0;
  assign win_sum_next = win_sum - SUM_W'(old_mag) + SUM_W'(net);

  always_ff @(posedge clk) begin
    if (rst) begin
      win_vld <= '0;
      wp      <= '0;
      win_sum <= '0;
    end else if (state == S_UPD) begin
      win_vld[wp] <= 1'b1;
      win_sum     <= win_sum_next;
      wp          <= (wp == WP_W'(WINDOW_LEN - 1)) ? '0 : wp + 1'b1;
    end
  end

  // The divider serves the window average first, then the speed on a step.
  assign spd_num   = MS_PER_S * SPD_W'(step_len);
  assign div_start = (state == S_AVG) || (state == S_SPD);
  assign div_num   = (state == S_SPD) ? DIV_W'(spd_num) : DIV_W'(win_sum);
  assign div_den   = (state == S_SPD) ? delta : TS_W'(WINDOW_LEN);

  aast_div #(.NUM_W(DIV_W), .DEN_W(TS_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .numer(div_num), .denom(div_den),
    .busy(div_busy), .quotient(div_quo)
  );

  always_ff @(posedge clk) begin
    if (state == S_AVGW && !div_busy) begin
      avg <= div_quo[MAG_W-1:0];
    end
  end

  // Activity class and step decision on the new average.
  always_comb begin
    if (avg < MAG_W'(rest_thr)) begin
      act_next = ACT_REST;
    end else if (avg < MAG_W'(run_thr)) begin
      act_next = ACT_WALK;
    end else begin
      act_next = ACT_RUN;
    end
  end

  assign step_now = armed && (avg > MAG_W'(step_thr));

  always_ff @(posedge clk) begin
    if (rst) begin
      armed    <= 1'b1;
      step_cnt <= '0;
      last_ts  <= '0;
    end else if (state == S_DEC) begin
      if (step_now) begin
        armed   <= 1'b0;
        last_ts <= ts_q;
        if (step_cnt != STEP_MAX) begin
          step_cnt <= step_cnt + 1'b1;
        end
      end else if (avg < MAG_W'(step_thr)) begin
        armed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DEC) begin
      act_q  <= act_next;
      step_q <= step_now;
      delta  <= ts_q - last_ts;
    end
  end

  // Distance is rebuilt from the count on every step.
  assign dist_start = (state == S_SPD);

  aast_mul #(.A_W(CNT_W), .B_W(STEP_LEN_W)) u_dist (
    .clk(clk), .rst(rst), .start(dist_start), .a(step_cnt), .b(step_len),
    .busy(dist_busy), .product(dist_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_hold <= '0;
      spd_hold  <= '0;
    end else if (state == S_SPDW && !div_busy && !dist_busy) begin
      dist_hold <= dist_prod;
      spd_hold  <= (delta == '0) ? '0 : div_quo[SPD_W-1:0];
    end
  end

  // Output register: holds a finished result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      activity       <= act_q;
      step_detected  <= step_q;
      step_total     <= step_cnt;
      distance_mm    <= dist_hold;
      speed_mm_per_s <= spd_hold;
      window_mean    <= avg;
    end
  end

  // Checks on the sequencer, the window bookkeeping and the step count.
  `AAST_ASSERT_NEXT(a_accept_holds_off, in_valid && in_ready, !in_ready,
                    "input accepted again before the item finished")
  `AAST_ASSERT_SAME(a_wp_in_range, 1'b1, wp < WINDOW_LEN,
                    "window write position out of range")
  `AAST_ASSERT_SAME(a_step_counted, out_valid && step_detected, step_total != '0,
                    "step reported with a zero step count")
  `AAST_ASSERT_SAME(a_result_from_fsm, $rose(out_valid), $past(state) == S_OUT,
                    "result register loaded outside the output state")

endmodule

/* dv/tb_accel_activity_step_tracker_top.sv */
`timescale 1ns / 1ps

module tb_accel_activity_step_tracker_top
  import aast_pkg::*;
();

  localparam int unsigned WIN_LEN           = 10;
  localparam int unsigned CYCLE_LIMIT       = 1500000;
  localparam int unsigned TAIL_CYCLES       = 200;
  localparam int unsigned HOLD_OFF_CYCLES   = 400;
  localparam int unsigned ITEMS_PER_SETTING = 270;

  // Indexes that name no register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HIGH = 8'hFF;

  // Expected contents of one result item.
  typedef struct packed {
    activity_t          act;
    logic               step;
    logic [CNT_W-1:0]   total;
    logic [DIST_W-1:0]  travel;
    logic [SPD_W-1:0]   speed;
    logic [MAG_W-1:0]   avg;
  } tracker_result_t;

  // One row of the directed plan: a register write or a sample item.
  typedef struct packed {
    logic                    is_write;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] z;
    logic [TS_W-1:0]         ts;
    logic                    typed;
    tracker_result_t         want;
  } plan_row_t;

  typedef enum int {SEG_QUIET, SEG_STRIDE, SEG_NOISE} segment_t;

  logic                    clk          = 1'b0;
  logic                    rst          = 1'b1;
  logic                    cfg_valid    = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index    = '0;
  logic [CFG_DATA_W-1:0]   cfg_data     = '0;
  logic                    in_valid     = 1'b0;
  logic                    in_ready;
  logic signed [ACC_W-1:0] acc_x        = '0;
  logic signed [ACC_W-1:0] acc_y        = '0;
  logic signed [ACC_W-1:0] acc_z        = '0;
  logic [TS_W-1:0]         timestamp_ms = '0;
  logic                    out_valid;
  logic                    out_ready    = 1'b0;
  logic [1:0]              activity;
  logic                    step_detected;
  logic [CNT_W-1:0]        step_total;
  logic [DIST_W-1:0]       distance_mm;
  logic [SPD_W-1:0]        speed_mm_per_s;
  logic [MAG_W-1:0]        window_mean;

  // Predictor copy of the registers and the tracker state.
  logic [STEP_LEN_W-1:0] stride_mm;
  logic [THR_W-1:0]      rest_thr;
  logic [THR_W-1:0]      run_thr;
  logic [THR_W-1:0]      step_thr;
  logic [MAG_W-1:0]      window_mag [WIN_LEN];
  int unsigned           window_pos;
  int unsigned           window_total;
  bit                    rearmed;
  logic [CNT_W-1:0]      steps_seen;
  logic [DIST_W-1:0]     dist_at_step;
  logic [TS_W-1:0]       last_step_ts;
  logic [SPD_W-1:0]      speed_at_step;

  tracker_result_t expected_q [$];
  plan_row_t       plan [$];
  int unsigned     mismatches   = 0;
  int unsigned     cycle_count  = 0;
  int unsigned     snd_idle_pct = 0;
  int unsigned     rcv_idle_pct = 0;
  bit              hold_off_go  = 1'b0;
  bit              hold_done    = 1'b0;
  int unsigned     hold_left    = 0;
  segment_t        seg_kind     = SEG_QUIET;
  int unsigned     seg_left     = 0;
  logic [TS_W-1:0] clock_ms     = '0;

  accel_activity_step_tracker_top #(
    .WINDOW_LEN(WIN_LEN)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .acc_x         (acc_x),
    .acc_y         (acc_y),
    .acc_z         (acc_z),
    .timestamp_ms  (timestamp_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .activity      (activity),
    .step_detected (step_detected),
    .step_total    (step_total),
    .distance_mm   (distance_mm),
    .speed_mm_per_s(speed_mm_per_s),
    .window_mean   (window_mean)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Put the predictor into its after-reset state.
  function automatic void tracker_reset();
    stride_mm     = STEP_LEN_RST;
    rest_thr      = REST_THR_RST;
    run_thr       = RUN_THR_RST;
    step_thr      = STEP_THR_RST;
    foreach (window_mag[i]) window_mag[i] = '0;
    window_pos    = 0;
    window_total  = 0;
    rearmed       = 1'b1;
    steps_seen    = '0;
    dist_at_step  = '0;
    last_step_ts  = '0;
    speed_at_step = '0;
  endfunction

  // Register write as the predictor sees it: masked, unknown indexes dropped.
  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_STEP_LENGTH: stride_mm = data[STEP_LEN_W-1:0];
      REG_REST_THR:    rest_thr  = data[THR_W-1:0];
      REG_RUN_THR:     run_thr   = data[THR_W-1:0];
      REG_STEP_THR:    step_thr  = data[THR_W-1:0];
      default: ;
    endcase
  endfunction

  // Floor square root, one result bit at a time from the top.
  function automatic int unsigned floor_root(longint unsigned n);
    longint unsigned trial;
    int unsigned     root;
    root = 0;
    for (int b = int'(ROOT_W) - 1; b >= 0; b--) begin
      trial = longint'(root | (32'd1 << b));
      if (trial * trial <= n) root = root | (32'd1 << b);
    end
    return root;
  endfunction

  // Advance the predictor by one sample item and return the result it causes.
  function automatic tracker_result_t predict_sample(logic signed [ACC_W-1:0] x,
                                                     logic signed [ACC_W-1:0] y,
                                                     logic signed [ACC_W-1:0] z,
                                                     logic [TS_W-1:0] ts);
    longint          sx;
    longint          sy;
    longint          sz;
    longint unsigned energy;
    int unsigned     mag;
    int unsigned     net;
    int unsigned     avg_now;
    logic [TS_W-1:0] delta;
    tracker_result_t r;
    sx     = x;
    sy     = y;
    sz     = z;
    energy = longint'(sx * sx + sy * sy + sz * sz);
    mag    = floor_root(energy);
    net    = (mag >= int'(ONE_G)) ? mag - int'(ONE_G) : int'(ONE_G) - mag;

    // Slide the window and take the truncated mean.
    window_total           = window_total - window_mag[window_pos] + net;
    window_mag[window_pos] = MAG_W'(net);
    window_pos             = (window_pos + 1) % WIN_LEN;
    avg_now                = window_total / WIN_LEN;

    // Classes are tested in order, so a high rest level hides walking.
    if (avg_now < rest_thr) r.act = ACT_REST;
    else if (avg_now < run_thr) r.act = ACT_WALK;
    else r.act = ACT_RUN;

    // Rising crossing counts; re-arm only once strictly below the level.
    r.step = 1'b0;
    if (avg_now > step_thr && rearmed) begin
      rearmed = 1'b0;
      r.step  = 1'b1;
    end else if (avg_now < step_thr) begin
      rearmed = 1'b1;
    end

    if (r.step) begin
      if (steps_seen != STEP_MAX) steps_seen = steps_seen + 1'b1;
      dist_at_step  = DIST_W'(longint'(steps_seen) * longint'(stride_mm));
      delta         = ts - last_step_ts;
      last_step_ts  = ts;
      speed_at_step = (delta != 0) ? SPD_W'((32'(stride_mm) * 32'd1000) / delta) : '0;
    end

    r.total  = steps_seen;
    r.travel = dist_at_step;
    r.speed  = speed_at_step;
    r.avg    = MAG_W'(avg_now);
    return r;
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row          = '0;
    row.is_write = 1'b1;
    row.idx      = idx;
    row.data     = data;
    plan.push_back(row);
  endfunction

  function automatic void add_sample(logic signed [ACC_W-1:0] x, logic signed [ACC_W-1:0] y,
                                     logic signed [ACC_W-1:0] z, logic [TS_W-1:0] ts,
                                     logic typed = 1'b0, tracker_result_t want = '0);
    plan_row_t row;
    row       = '0;
    row.x     = x;
    row.y     = y;
    row.z     = z;
    row.ts    = ts;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Offer one sample item, with random gaps first, and queue its expected result.
  task automatic send_sample(logic signed [ACC_W-1:0] x, logic signed [ACC_W-1:0] y,
                             logic signed [ACC_W-1:0] z, logic [TS_W-1:0] ts,
                             logic typed = 1'b0, tracker_result_t want = '0);
    tracker_result_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    acc_x        <= x;
    acc_y        <= y;
    acc_z        <= z;
    timestamp_ms <= ts;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_sample(x, y, z, ts);
    expected_q.push_back(typed ? want : predicted);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_write(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering items and wait for every outstanding result.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_random_settings();
    logic [CFG_DATA_W-1:0] stride_val;
    logic [CFG_DATA_W-1:0] rest_val;
    logic [CFG_DATA_W-1:0] run_val;
    logic [CFG_DATA_W-1:0] step_val;
    stride_val = ($urandom_range(0, 99) < 25) ? CFG_DATA_W'($urandom())
                                              : CFG_DATA_W'($urandom_range(0, 2000));
    rest_val   = ($urandom_range(0, 99) < 10) ? CFG_DATA_W'($urandom())
                                              : CFG_DATA_W'($urandom_range(0, 3000));
    run_val    = ($urandom_range(0, 99) < 10) ? CFG_DATA_W'($urandom())
                                              : CFG_DATA_W'($urandom_range(2000, 12000));
    step_val   = ($urandom_range(0, 99) < 10) ? CFG_DATA_W'($urandom())
                                              : CFG_DATA_W'($urandom_range(1000, 10000));
    write_reg(REG_STEP_LENGTH, stride_val);
    write_reg(REG_REST_THR, rest_val);
    write_reg(REG_RUN_THR, run_val);
    write_reg(REG_STEP_THR, step_val);
    write_reg(CFG_IDX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom()));
  endtask

  // Random samples in segments: quiet near one g, strides with large swings, or raw noise.
  task automatic send_random_sample();
    logic signed [ACC_W-1:0] ax;
    logic signed [ACC_W-1:0] ay;
    logic signed [ACC_W-1:0] az;
    logic signed [ACC_W-1:0] swap;
    int unsigned             pick;
    if (seg_left == 0) begin
      pick     = $urandom_range(0, 99);
      seg_kind = (pick < 40) ? SEG_QUIET : (pick < 85) ? SEG_STRIDE : SEG_NOISE;
      seg_left = $urandom_range(2, 14);
    end
    seg_left--;

    case (seg_kind)
      SEG_QUIET: begin
        ax = ACC_W'(int'($urandom_range(0, 800)) - 400);
        ay = ACC_W'(int'($urandom_range(0, 800)) - 400);
        az = ACC_W'(8192 + int'($urandom_range(0, 1200)) - 600);
        if ($urandom_range(0, 1) != 0) az = -az;
      end
      SEG_STRIDE: begin
        ax = ACC_W'(int'($urandom_range(0, 16000)) - 8000);
        ay = ACC_W'(int'($urandom_range(0, 16000)) - 8000);
        az = ACC_W'(int'($urandom_range(12000, 32767)));
        if ($urandom_range(0, 1) != 0) az = -az;
      end
      default: begin
        ax = ACC_W'($urandom());
        ay = ACC_W'($urandom());
        az = ACC_W'($urandom());
      end
    endcase
    if ($urandom_range(0, 2) == 0) begin
      swap = ax;
      ax   = az;
      az   = swap;
    end

    // Mostly steady time, with repeats, returns to the last step time and jumps.
    pick = $urandom_range(0, 99);
    if (pick < 80) clock_ms = clock_ms + TS_W'($urandom_range(1, 600));
    else if (pick < 88) clock_ms = clock_ms;
    else if (pick < 92) clock_ms = last_step_ts;
    else clock_ms = TS_W'($urandom());

    send_sample(ax, ay, az, clock_ms);
  endtask

  // Compare every accepted result item with the oldest expectation.
  always @(posedge clk) begin
    tracker_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result item with nothing expected, expected none, got avg %0d",
                 $time, window_mean);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("activity", 64'(want.act), 64'(activity));
        check_field("step_detected", 64'(want.step), 64'(step_detected));
        check_field("step_total", 64'(want.total), 64'(step_total));
        check_field("distance_mm", 64'(want.travel), 64'(distance_mm));
        check_field("speed_mm_per_s", 64'(want.speed), 64'(speed_mm_per_s));
        check_field("window_mean", 64'(want.avg), 64'(window_mean));
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off once requested.
  always @(negedge clk) begin
    if (hold_off_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Main sequence: reset, directed plan, then random phases.
  initial begin
    tracker_reset();

    // Equality with the rest level, then a step with no time elapsed.
    add_write(REG_STEP_THR, 16'd819);
    add_sample(16'sd0, 16'sd0, 16'sd0, 32'd0, 1'b1,
               tracker_result_t'{ACT_WALK, 1'b0, 24'd0, 35'd0, 21'd0, 16'd819});
    add_sample(16'sd0, 16'sd0, 16'sd0, 32'd0, 1'b1,
               tracker_result_t'{ACT_WALK, 1'b1, 24'd1, 35'd600, 21'd0, 16'd1638});
    // Average sitting on the step level must neither count nor re-arm.
    add_write(REG_STEP_THR, 16'd1638);
    add_sample(16'sd0, 16'sd0, 16'sd8192, 32'd250);
    add_sample(16'sd0, -16'sd8192, 16'sd0, 32'd500);
    // Drop below to re-arm, then count with the widest stride.
    add_write(REG_STEP_THR, 16'd2000);
    add_sample(16'sd8192, 16'sd0, 16'sd0, 32'd750);
    add_write(REG_STEP_THR, 16'd1000);
    add_write(REG_STEP_LENGTH, 16'hFFFF);
    add_sample(-16'sd8192, 16'sd0, 16'sd0, 32'd1000, 1'b1,
               tracker_result_t'{ACT_WALK, 1'b1, 24'd2, 35'd4094, 21'd2047, 16'd1638});
    // Rest level above run level, step level at zero, axis extremes.
    add_write(REG_REST_THR, 16'h7FFF);
    add_write(REG_RUN_THR, 16'd0);
    add_write(REG_STEP_THR, 16'd0);
    add_sample(-16'sd32768, -16'sd32768, -16'sd32768, 32'hFFFF_FFFF);
    add_sample(16'sd32767, 16'sd32767, 16'sd32767, 32'd0);
    add_sample(16'sd32767, -16'sd32768, 16'sd0, 32'd1);
    // Opposite extremes of the levels, zero stride.
    add_write(REG_REST_THR, 16'd0);
    add_write(REG_RUN_THR, 16'hFFFF);
    add_write(REG_STEP_THR, 16'hFFFF);
    add_write(REG_STEP_LENGTH, 16'd0);
    add_sample(-16'sd1, -16'sd1, -16'sd1, 32'd2);
    add_sample(16'sd1, 16'sd1, 16'sd1, 32'd3);
    // A step with zero stride; writes to unknown indexes must change nothing.
    add_write(REG_STEP_THR, 16'd0);
    add_write(REG_UNUSED_LOW, 16'hFFFF);
    add_write(REG_UNUSED_HIGH, 16'hFFFF);
    add_sample(16'sd0, 16'sd0, 16'sd0, 32'd40);
    // Back to the reset values.
    add_write(REG_STEP_LENGTH, 16'(STEP_LEN_RST));
    add_write(REG_REST_THR, 16'(REST_THR_RST));
    add_write(REG_RUN_THR, 16'(RUN_THR_RST));
    add_write(REG_STEP_THR, 16'(STEP_THR_RST));
    add_sample(16'sd16384, -16'sd16384, 16'sd16384, 32'd12345);
    add_sample(-16'sd12345, 16'sd23456, -16'sd7, 32'h8000_0000);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    snd_idle_pct = 20;
    rcv_idle_pct = 20;
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_sample(plan[i].x, plan[i].y, plan[i].z, plan[i].ts, plan[i].typed, plan[i].want);
      end
    end

    // Random part: sender idles lightly, then the receiver, then neither.
    for (int phase = 0; phase < 3; phase++) begin
      snd_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 87 : 0;
      rcv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 8 : 0;
      for (int setting = 0; setting < 2; setting++) begin
        wait_idle();
        write_random_settings();
        if (phase == 2 && setting == 0) hold_off_go = 1'b1;
        repeat (ITEMS_PER_SETTING) send_random_sample();
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
